@@ rtl/core/asfp_pkg.sv @@
// Shared types, constants and register map of the sample filter and presence unit.
package asfp_pkg;

    localparam int SAMPLE_BITS    = 12;
    localparam int WARMUP_SAMPLES = 10;
    localparam int TIME_BITS      = 16;

    localparam int CFG_BITS       = 16;
    localparam int APB_DATA_BITS  = 32;
    localparam int APB_ADDR_BITS  = 4;

    localparam int WARMUP_BITS    = (WARMUP_SAMPLES > 0) ? $clog2(WARMUP_SAMPLES + 1) : 1;
    localparam int TIME_SUM_BITS  = ((TIME_BITS > CFG_BITS) ? TIME_BITS : CFG_BITS) + 1;
    localparam int PROD_BITS      = CFG_BITS + 1 + SAMPLE_BITS + 2;

    localparam logic [TIME_BITS-1:0]   TIME_MAX   = {TIME_BITS{1'b1}};
    localparam logic [WARMUP_BITS-1:0] WARMUP_END = WARMUP_BITS'(WARMUP_SAMPLES);

    // register reset values
    localparam logic [CFG_BITS-1:0] ALPHA_RESET   = 16'd14564;
    localparam logic [CFG_BITS-1:0] PERIOD_RESET  = 16'd100;
    localparam logic [CFG_BITS-1:0] PRESENT_RESET = 16'd1000;
    localparam logic [CFG_BITS-1:0] MISSING_RESET = 16'd1000;

    // register indexes (byte address / 4)
    localparam logic [1:0] REG_ALPHA   = 2'd0;
    localparam logic [1:0] REG_PERIOD  = 2'd1;
    localparam logic [1:0] REG_PRESENT = 2'd2;
    localparam logic [1:0] REG_MISSING = 2'd3;

    typedef enum logic [1:0] {
        STATUS_UNKNOWN = 2'd0,
        STATUS_PRESENT = 2'd1,
        STATUS_MISSING = 2'd2
    } status_t;

    typedef struct packed {
        logic [CFG_BITS-1:0] alpha;
        logic [CFG_BITS-1:0] period;
        logic [CFG_BITS-1:0] present_deb;
        logic [CFG_BITS-1:0] missing_deb;
    } cfg_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample_value;
        logic                   sample_error;
    } in_beat_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS:0] filtered_value;
        logic [1:0]                  input_status;
    } out_beat_t;

endpackage

@@ rtl/core/asfp_cfg.sv @@
// APB register file holding the filter coefficient, sample period and debounce times.
module asfp_cfg
    import asfp_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready,
    output cfg_t                     cfg
);

    cfg_t       cfg_reg;
    logic [1:0] index;
    logic       wr_en;

    assign index  = paddr[3:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // write on the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.alpha       <= ALPHA_RESET;
            cfg_reg.period      <= PERIOD_RESET;
            cfg_reg.present_deb <= PRESENT_RESET;
            cfg_reg.missing_deb <= MISSING_RESET;
        end
        else if (wr_en)
        begin
            case (index)
                REG_ALPHA:   cfg_reg.alpha       <= pwdata[CFG_BITS-1:0];
                REG_PERIOD:  cfg_reg.period      <= pwdata[CFG_BITS-1:0];
                REG_PRESENT: cfg_reg.present_deb <= pwdata[CFG_BITS-1:0];
                REG_MISSING: cfg_reg.missing_deb <= pwdata[CFG_BITS-1:0];
                default:     cfg_reg.alpha       <= cfg_reg.alpha;
            endcase
        end
    end

    // read back
    always_comb
    begin
        case (index)
            REG_ALPHA:   prdata = APB_DATA_BITS'(cfg_reg.alpha);
            REG_PERIOD:  prdata = APB_DATA_BITS'(cfg_reg.period);
            REG_PRESENT: prdata = APB_DATA_BITS'(cfg_reg.present_deb);
            REG_MISSING: prdata = APB_DATA_BITS'(cfg_reg.missing_deb);
            default:     prdata = '0;
        endcase
    end

endmodule

@@ rtl/core/asfp_core.sv @@
// Per-sample state update: elapsed-time counters, presence status and EMA filter.
module asfp_core
    import asfp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      step,
    input  in_beat_t  beat,
    output out_beat_t result
);

    logic [SAMPLE_BITS-1:0]  prev_reg, prev_next;
    logic [TIME_BITS-1:0]    fl_reg, fl_next;
    logic [TIME_BITS-1:0]    st_reg, st_next;
    status_t                 status_reg, status_next;
    logic signed [SAMPLE_BITS:0] filt_reg, filt_next;
    logic [WARMUP_BITS-1:0]  warm_reg, warm_next;

    logic [TIME_SUM_BITS-1:0]    fl_sum, st_sum;
    logic [TIME_BITS-1:0]        fl_adv, st_adv;
    logic signed [SAMPLE_BITS+1:0] diff;
    logic signed [CFG_BITS:0]    alpha_s;
    logic signed [PROD_BITS-1:0] prod;
    logic signed [PROD_BITS-1:0] prod_sh;
    logic signed [SAMPLE_BITS:0] ema;

    // advance both timers by one sample period, saturating
    assign fl_sum = TIME_SUM_BITS'(fl_reg) + TIME_SUM_BITS'(cfg.period);
    assign st_sum = TIME_SUM_BITS'(st_reg) + TIME_SUM_BITS'(cfg.period);
    assign fl_adv = (fl_sum > TIME_SUM_BITS'(TIME_MAX)) ? TIME_MAX : fl_sum[TIME_BITS-1:0];
    assign st_adv = (st_sum > TIME_SUM_BITS'(TIME_MAX)) ? TIME_MAX : st_sum[TIME_BITS-1:0];

    // EMA as f + floor(a * (x - f) / 2^16)
    assign diff    = $signed({2'b00, beat.sample_value}) - $signed({filt_reg[SAMPLE_BITS], filt_reg});
    assign alpha_s = $signed({1'b0, cfg.alpha});
    assign prod    = PROD_BITS'(alpha_s * diff);
    assign prod_sh = prod >>> CFG_BITS;
    assign ema     = filt_reg + prod_sh[SAMPLE_BITS:0];

    // next state
    always_comb
    begin
        prev_next   = prev_reg;
        fl_next     = fl_adv;
        st_next     = st_adv;
        status_next = status_reg;
        filt_next   = filt_reg;
        warm_next   = warm_reg;

        if (beat.sample_error)
        begin
            status_next = STATUS_UNKNOWN;
            filt_next   = '1;
        end
        else
        begin
            if (beat.sample_value != prev_reg)
            begin
                prev_next = beat.sample_value;
                st_next   = '0;
                if (status_reg != STATUS_PRESENT &&
                    TIME_SUM_BITS'(fl_adv) >= TIME_SUM_BITS'(cfg.present_deb))
                begin
                    status_next = STATUS_PRESENT;
                end
            end
            else
            begin
                fl_next = '0;
                if (status_reg != STATUS_MISSING &&
                    TIME_SUM_BITS'(st_adv) >= TIME_SUM_BITS'(cfg.missing_deb))
                begin
                    status_next = STATUS_MISSING;
                end
            end

            // pass raw during warm-up and after an error
            if (warm_reg < WARMUP_END)
            begin
                warm_next = warm_reg + 1'b1;
                filt_next = $signed({1'b0, beat.sample_value});
            end
            else if (filt_reg[SAMPLE_BITS])
            begin
                filt_next = $signed({1'b0, beat.sample_value});
            end
            else
            begin
                filt_next = ema;
            end
        end
    end

    // hold state between beats
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg   <= '0;
            fl_reg     <= '0;
            st_reg     <= '0;
            status_reg <= STATUS_UNKNOWN;
            filt_reg   <= '1;
            warm_reg   <= '0;
        end
        else if (step)
        begin
            prev_reg   <= prev_next;
            fl_reg     <= fl_next;
            st_reg     <= st_next;
            status_reg <= status_next;
            filt_reg   <= filt_next;
            warm_reg   <= warm_next;
        end
    end

    assign result.filtered_value = filt_next;
    assign result.input_status   = status_next;

endmodule

@@ rtl/core/adc_sample_filter_presence_unit.sv @@
// Top level of the ADC sample filter and presence unit.
//
// Usage:
//   sample channel (sample_valid/sample_ready/sample): one converter reading
//   per beat with its error flag. result channel (result_valid/result_ready/
//   result): one beat per sample, the filtered reading (-1 after an error)
//   and the input status (unknown, present, missing).
//   APB port: four 16-bit registers at byte addresses 0, 4, 8, 12 (filter
//   coefficient, sample period, present debounce, missing debounce); write
//   them only while no sample is in flight.
// Pipeline and throughput:
//   a sample lands in the input register, then its state update runs and
//   the result register loads once the result register is free. One sample
//   per cycle is sustained while result_ready stays high; the state update
//   (one 17x14 multiply and two saturating adds) closes the feedback loop.
// Reset:
//   rst_n clears the timers, warm-up count and status, sets the filter to -1
//   and restores the register defaults.
// Stalls:
//   with result_ready low the result holds, one more sample is taken into the
//   input register, then sample_ready drops until the result is taken.
module adc_sample_filter_presence_unit
    import asfp_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     sample_valid,
    output logic                     sample_ready,
    input  in_beat_t                 sample,
    output logic                     result_valid,
    input  logic                     result_ready,
    output out_beat_t                result,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready
);

    cfg_t      cfg;
    in_beat_t  stage_reg;
    logic      stage_valid_reg;
    out_beat_t out_reg;
    logic      out_valid_reg;
    out_beat_t core_result;
    logic      advance;
    logic      step;

    asfp_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    asfp_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .step   (step),
        .beat   (stage_reg),
        .result (core_result)
    );

    // output register frees when empty or drained
    assign advance      = !out_valid_reg || result_ready;
    assign step         = stage_valid_reg && advance;
    assign sample_ready = !stage_valid_reg || advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (sample_ready)
        begin
            stage_valid_reg <= sample_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_ready && sample_valid)
        begin
            stage_reg <= sample;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= stage_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_reg <= core_result;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // a negative filter value only ever goes with unknown status
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.filtered_value[SAMPLE_BITS] |->
            result.input_status == STATUS_UNKNOWN)
        else $error("negative filter value with known status");

    // negative filter value is exactly -1
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.filtered_value[SAMPLE_BITS] |->
            result.filtered_value == '1)
        else $error("filter value below -1");

    // a staged sample held behind a stalled result stays staged
    assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid_reg && result_valid && !result_ready |=> stage_valid_reg)
        else $error("staged sample lost during stall");

    // a processed sample always shows up at the result register
    assert property (@(posedge clk) disable iff (!rst_n)
        step |=> result_valid)
        else $error("processed sample produced no result");

endmodule
